// File: rtl/core/hpbk_pkg.sv
// shared types and constants for the packed byte key heapsort block
package hpbk_pkg;

  localparam int KEY_W    = 64;
  localparam int IDX_W    = 6;
  localparam int POS_W    = 6;
  localparam int KIND_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int TDATA_W  = 80;
  localparam int TUSER_W  = 2;
  localparam int PAD_W    = TDATA_W - (POS_W + IDX_W + KEY_W);

  localparam logic [KEY_W-1:0] KEY_RADIX = 64'd1000;

  localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
  } entry_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] addr;
    entry_t           ent;
  } ld_req_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
    logic             last;
    logic             empty;
  } res_t;

endpackage

// File: rtl/core/heapsort_packed_byte_keys.sv
// byte and close items are taken while in_tready is high; end of list holds in_tready low until all results go
// heap build reads and loads each node (S_BRD, S_BLD), then sifts it down level by level (S_SL, S_SR, S_SC)
// each extraction reads root and tail (S_XR0, S_XRI), moves the old root to the tail (S_XLD), then sifts from the root
// every sorted result goes through memory read, result load and handshake, and waits there on any output stall
// synchronous active-low reset clears count, key, overflow flag and sequencer; memory is not cleared
// top level: key accumulation, entry loading and stream ports of the heapsort block
module heapsort_packed_byte_keys #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [hpbk_pkg::BYTE_W-1:0]    in_tdata,  // [7:0] byte_value
  input  logic [hpbk_pkg::KIND_W-1:0]    in_tuser,  // [1:0] kind
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [hpbk_pkg::TDATA_W-1:0]   out_tdata, // [5:0] sorted_position, [11:6] source_index,
                                                    // [75:12] sort_key, [79:76] zero
  output logic                           out_tlast, // last_result
  output logic [hpbk_pkg::TUSER_W-1:0]   out_tuser  // [0] list_empty, [1] overflowed
);
  import hpbk_pkg::*;

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic [KEY_W-1:0] acc_r, acc_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             in_acc;
  ld_req_t          ld;
  logic             start;
  logic             busy;
  logic             done;
  res_t             res;
  logic             res_valid;

  assign in_tready = !busy;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    ld        = '0;
    ld.ent    = '{key: acc_r, idx: IDX_W'(cnt_r[IW-1:0])};
    ld.addr   = IDX_W'(cnt_r[IW-1:0]);
    start     = 1'b0;
    if (in_acc) begin
      case (in_tuser)
        KIND_BYTE: begin
          acc_nxt = acc_r * KEY_RADIX + KEY_W'(in_tdata);
        end
        KIND_CLOSE: begin
          if (cnt_r < CW'(MAX_ITEMS)) begin
            ld.valid = 1'b1;
            cnt_nxt  = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          acc_nxt = '0;
        end
        KIND_END: begin
          start = 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (done) begin
      acc_nxt = '0;
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  hpbk_sorter #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_sorter (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (ld),
    .start     (start),
    .start_n   (cnt_r),
    .busy      (busy),
    .done      (done),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (out_tready)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = {{PAD_W{1'b0}}, res.key, res.idx, res.pos};
  assign out_tlast  = res.last;
  assign out_tuser  = {ovf_r & ~res.empty, res.empty};

endmodule

// File: rtl/core/hpbk_sorter.sv
// entry memory with the heapsort sequencer and the result register
module hpbk_sorter #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hpbk_pkg::ld_req_t                 ld,
  input  logic                              start,
  input  logic [$clog2(MAX_ITEMS+1)-1:0]    start_n,
  output logic                              busy,
  output logic                              done,
  output hpbk_pkg::res_t                    res,
  output logic                              res_valid,
  input  logic                              res_ready
);
  import hpbk_pkg::*;

  localparam int IW  = $clog2(MAX_ITEMS);
  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int CHW = IW + 2;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BRD   = 4'd1;
  localparam logic [3:0] S_BLD   = 4'd2;
  localparam logic [3:0] S_SL    = 4'd3;
  localparam logic [3:0] S_SR    = 4'd4;
  localparam logic [3:0] S_SC    = 4'd5;
  localparam logic [3:0] S_XR0   = 4'd6;
  localparam logic [3:0] S_XRI   = 4'd7;
  localparam logic [3:0] S_XLD   = 4'd8;
  localparam logic [3:0] S_ERD   = 4'd9;
  localparam logic [3:0] S_ELD   = 4'd10;
  localparam logic [3:0] S_EHOLD = 4'd11;

  entry_t mem [MAX_ITEMS];
  entry_t rd_data_r;

  logic [3:0]    st_r, st_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] p_r, p_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] size_r, size_nxt;
  logic [IW-1:0] node_r, node_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic          build_r, build_nxt;
  logic          rok_r, rok_nxt;
  entry_t        v_r, v_nxt;
  entry_t        l_r, l_nxt;
  res_t          res_r, res_nxt;
  logic          res_valid_r, res_valid_nxt;

  logic          we;
  logic [IW-1:0] wa;
  entry_t        wd;
  logic [IW-1:0] ra;
  logic [CHW-1:0] left_w, right_w;
  logic          fin;
  logic          gl, gr;
  logic [KEY_W-1:0] tkey;

  assign left_w  = {1'b0, node_r, 1'b1};
  assign right_w = left_w + CHW'(1);

  // memory accesses are sequenced so that a read made in the same cycle as a write is never used
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[ra];
  end

  always_comb begin
    st_nxt        = st_r;
    n_nxt         = n_r;
    p_nxt         = p_r;
    i_nxt         = i_r;
    size_nxt      = size_r;
    node_nxt      = node_r;
    k_nxt         = k_r;
    build_nxt     = build_r;
    rok_nxt       = rok_r;
    v_nxt         = v_r;
    l_nxt         = l_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r;
    we            = 1'b0;
    wa            = '0;
    wd            = v_r;
    ra            = '0;
    fin           = 1'b0;
    done          = 1'b0;
    gl            = $signed(l_r.key) > $signed(v_r.key);
    tkey          = gl ? l_r.key : v_r.key;
    gr            = rok_r && ($signed(rd_data_r.key) > $signed(tkey));

    case (st_r)
      S_IDLE: begin
        if (ld.valid) begin
          we = 1'b1;
          wa = ld.addr[IW-1:0];
          wd = ld.ent;
        end
        if (start) begin
          n_nxt = start_n;
          k_nxt = '0;
          if (start_n == '0) begin
            res_nxt       = '0;
            res_nxt.empty = 1'b1;
            res_valid_nxt = 1'b1;
            st_nxt        = S_EHOLD;
          end else if (start_n == CW'(1)) begin
            st_nxt = S_ERD;
          end else begin
            p_nxt     = ((start_n - CW'(1)) >> 1) + CW'(1);
            build_nxt = 1'b1;
            st_nxt    = S_BRD;
          end
        end
      end
      S_BRD: begin
        ra       = IW'(p_r - CW'(1));
        node_nxt = IW'(p_r - CW'(1));
        p_nxt    = p_r - CW'(1);
        st_nxt   = S_BLD;
      end
      S_BLD: begin
        v_nxt    = rd_data_r;
        size_nxt = n_r;
        st_nxt   = S_SL;
      end
      S_SL: begin
        if (left_w >= CHW'(size_r)) begin
          we  = 1'b1;
          wa  = node_r;
          wd  = v_r;
          fin = 1'b1;
        end else begin
          ra     = left_w[IW-1:0];
          st_nxt = S_SR;
        end
      end
      S_SR: begin
        l_nxt   = rd_data_r;
        rok_nxt = right_w < CHW'(size_r);
        ra      = right_w[IW-1:0];
        st_nxt  = S_SC;
      end
      S_SC: begin
        we = 1'b1;
        wa = node_r;
        if (gr) begin
          wd       = rd_data_r;
          node_nxt = right_w[IW-1:0];
          st_nxt   = S_SL;
        end else if (gl) begin
          wd       = l_r;
          node_nxt = left_w[IW-1:0];
          st_nxt   = S_SL;
        end else begin
          wd  = v_r;
          fin = 1'b1;
        end
      end
      S_XR0: begin
        ra     = '0;
        st_nxt = S_XRI;
      end
      S_XRI: begin
        l_nxt  = rd_data_r;
        ra     = IW'(i_r);
        st_nxt = S_XLD;
      end
      S_XLD: begin
        // old root goes to the tail, tail entry sifts down from the root
        we       = 1'b1;
        wa       = IW'(i_r);
        wd       = l_r;
        v_nxt    = rd_data_r;
        node_nxt = '0;
        size_nxt = i_r;
        st_nxt   = S_SL;
      end
      S_ERD: begin
        ra     = k_r;
        st_nxt = S_ELD;
      end
      S_ELD: begin
        res_nxt.pos   = POS_W'(k_r);
        res_nxt.idx   = rd_data_r.idx;
        res_nxt.key   = rd_data_r.key;
        res_nxt.last  = (k_r == IW'(n_r - CW'(1)));
        res_nxt.empty = 1'b0;
        res_valid_nxt = 1'b1;
        st_nxt        = S_EHOLD;
      end
      S_EHOLD: begin
        if (res_ready) begin
          res_valid_nxt = 1'b0;
          if (res_r.last || res_r.empty) begin
            done   = 1'b1;
            st_nxt = S_IDLE;
          end else begin
            k_nxt  = k_r + IW'(1);
            st_nxt = S_ERD;
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      if (build_r) begin
        if (p_r == '0) begin
          build_nxt = 1'b0;
          i_nxt     = n_r - CW'(1);
          st_nxt    = S_XR0;
        end else begin
          st_nxt = S_BRD;
        end
      end else if (i_r == CW'(1)) begin
        k_nxt  = '0;
        st_nxt = S_ERD;
      end else begin
        i_nxt  = i_r - CW'(1);
        st_nxt = S_XR0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      res_valid_r <= res_valid_nxt;
    end
    n_r     <= n_nxt;
    p_r     <= p_nxt;
    i_r     <= i_nxt;
    size_r  <= size_nxt;
    node_r  <= node_nxt;
    k_r     <= k_nxt;
    build_r <= build_nxt;
    rok_r   <= rok_nxt;
    v_r     <= v_nxt;
    l_r     <= l_nxt;
    res_r   <= res_nxt;
  end

  assign busy      = (st_r != S_IDLE);
  assign res       = res_r;
  assign res_valid = res_valid_r;

endmodule

// File: rtl/core/hpbk_checker.sv
// port-level checks for the heapsort block and their bind
module hpbk_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [hpbk_pkg::TDATA_W-1:0] out_tdata,
  input logic                         out_tlast,
  input logic [hpbk_pkg::TUSER_W-1:0] out_tuser
);
  import hpbk_pkg::*;

  // results wait on the output with input held off
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0 && !out_tlast && !out_tuser[1])
    else $error("empty-list result carries data");

  a_end_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && (out_tlast || out_tuser[0]) |=> in_tready && !out_tvalid)
    else $error("block not idle after final result");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind heapsort_packed_byte_keys hpbk_checker u_hpbk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// File: bench/tb_heapsort_packed_byte_keys.sv
// testbench for the packed byte key heapsort block: directed table, random lists, predicted results
`timescale 1ns / 1ps

module tb_heapsort_packed_byte_keys;
  import hpbk_pkg::*;

  localparam int CAPACITY = 64;
  localparam int RANDOM_ITEMS = 128;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 64;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [5:0]  pos;
    logic [5:0]  idx;
    logic [63:0] key;
    logic        last;
    logic        empty;
    logic        ovf;
  } sorted_entry_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [7:0]        value;
    logic              typed;
    sorted_entry_t     want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [BYTE_W-1:0]   in_tdata = '0;  // [7:0] byte_value
  logic [KIND_W-1:0]   in_tuser = '0;  // [1:0] kind
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [TDATA_W-1:0]  out_tdata;      // [5:0] sorted_position, [11:6] source_index, [75:12] sort_key
  logic                out_tlast;
  logic [TUSER_W-1:0]  out_tuser;      // [0] list_empty, [1] overflowed

  heapsort_packed_byte_keys #(.MAX_ITEMS(CAPACITY)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic signed [63:0] slot_key [CAPACITY];
  logic [5:0]         slot_idx [CAPACITY];
  int                 stored_count = 0;
  logic [63:0]        key_acc = '0;
  logic               dropped = 1'b0;
  sorted_entry_t      awaited_entries [$];

  int                 mismatch_count = 0;
  int                 cycle_count = 0;
  int                 burst_left = 0;
  logic               row_typed = 1'b0;
  sorted_entry_t      row_want = '0;
  stim_row_t          stim_rows [$];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  function automatic void heap_swap(input int a, input int b);
    logic signed [63:0] tk;
    logic [5:0]         ti;
    tk = slot_key[a];
    ti = slot_idx[a];
    slot_key[a] = slot_key[b];
    slot_idx[a] = slot_idx[b];
    slot_key[b] = tk;
    slot_idx[b] = ti;
  endfunction

  function automatic void heap_sift_down(input int size, input int start);
    int node;
    int top;
    node = start;
    while (1'b1) begin
      top = node;
      if (2 * node + 1 < size && slot_key[2 * node + 1] > slot_key[top]) top = 2 * node + 1;
      if (2 * node + 2 < size && slot_key[2 * node + 2] > slot_key[top]) top = 2 * node + 2;
      if (top == node) break;
      heap_swap(node, top);
      node = top;
    end
  endfunction

  // follows one accepted item and queues the entries it sends out
  function automatic void sorter_track(input logic [KIND_W-1:0] kind, input logic [7:0] value,
                                       input logic typed, input sorted_entry_t want);
    sorted_entry_t run [$];
    sorted_entry_t e;
    int            p;
    case (kind)
      KIND_BYTE: begin
        key_acc = key_acc * KEY_RADIX + {56'd0, value};
      end
      KIND_CLOSE: begin
        if (stored_count < CAPACITY) begin
          slot_key[stored_count] = key_acc;
          slot_idx[stored_count] = stored_count[5:0];
          stored_count++;
        end else begin
          dropped = 1'b1;
        end
        key_acc = '0;
      end
      KIND_END: begin
        if (stored_count == 0) begin
          e = '0;
          e.empty = 1'b1;
          run.push_back(e);
        end else begin
          for (p = (stored_count - 1) / 2; p >= 0; p--) heap_sift_down(stored_count, p);
          for (p = stored_count - 1; p > 0; p--) begin
            heap_swap(0, p);
            heap_sift_down(p, 0);
          end
          for (p = 0; p < stored_count; p++) begin
            e.pos   = p[5:0];
            e.idx   = slot_idx[p];
            e.key   = slot_key[p];
            e.last  = (p == stored_count - 1);
            e.empty = 1'b0;
            e.ovf   = dropped;
            run.push_back(e);
          end
        end
        stored_count = 0;
        key_acc = '0;
        dropped = 1'b0;
        if (typed) awaited_entries.push_back(want);
        else foreach (run[i]) awaited_entries.push_back(run[i]);
      end
      default: begin
      end
    endcase
  endfunction

  task automatic check_entry();
    sorted_entry_t want;
    if (awaited_entries.size() == 0) begin
      report_mismatch("result with nothing awaited, key", out_tdata[75:12], '0);
      return;
    end
    want = awaited_entries.pop_front();
    if (out_tdata[5:0] != want.pos)
      report_mismatch("sorted_position", 64'(out_tdata[5:0]), 64'(want.pos));
    if (out_tdata[11:6] != want.idx)
      report_mismatch("source_index", 64'(out_tdata[11:6]), 64'(want.idx));
    if (out_tdata[75:12] != want.key) report_mismatch("sort_key", out_tdata[75:12], want.key);
    if (out_tlast != want.last) report_mismatch("last_result", 64'(out_tlast), 64'(want.last));
    if (out_tuser[0] != want.empty)
      report_mismatch("list_empty", 64'(out_tuser[0]), 64'(want.empty));
    if (out_tuser[1] != want.ovf)
      report_mismatch("overflowed", 64'(out_tuser[1]), 64'(want.ovf));
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sorter_track(in_tuser, in_tdata, row_typed, row_want);
      if (out_tvalid && out_tready) check_entry();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: picks a new stall pattern at random whenever the low seven bits of its tick counter are zero
  logic [31:0] rx_tick = '0;
  logic [1:0]  rx_mode = '0;
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick[6:0] == '0) rx_mode <= 2'($urandom_range(0, 3));
    case (rx_mode)
      2'd0:    out_tready <= 1'b1;
      2'd1:    out_tready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_tready <= (rx_tick[1:0] == 2'd3);
      default: out_tready <= (rx_tick[4:0] > 5'd19);
    endcase
  end

  // sender: bursts of random length with random gaps, valid held high inside a burst
  task automatic push_item(input logic [KIND_W-1:0] kind, input logic [7:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid = 1'b1;
    in_tuser = kind;
    in_tdata = value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_tvalid = 1'b0;
    while (awaited_entries.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic void add_row(input logic [KIND_W-1:0] kind, input logic [7:0] value,
                                  input logic typed, input sorted_entry_t want);
    stim_row_t r;
    r.kind = kind;
    r.value = value;
    r.typed = typed;
    r.want = want;
    stim_rows.push_back(r);
  endfunction

  // mostly the extremes and tiny values so that equal keys turn up often
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'($urandom_range(0, 3));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int strings;
    int nbytes;
    int list_no;
    int random_items;
    logic broken;

    // empty list straight after reset
    add_row(KIND_END, 8'h00, 1'b1, '{6'd0, 6'd0, 64'd0, 1'b0, 1'b1, 1'b0});
    add_row(KIND_SPARE, 8'hAA, 1'b0, '0);
    // string with no bytes
    add_row(KIND_CLOSE, 8'h00, 1'b0, '0);
    add_row(KIND_END, 8'h00, 1'b1, '{6'd0, 6'd0, 64'd0, 1'b1, 1'b0, 1'b0});
    add_row(KIND_BYTE, 8'hFF, 1'b0, '0);
    add_row(KIND_CLOSE, 8'h00, 1'b0, '0);
    add_row(KIND_END, 8'h00, 1'b1, '{6'd0, 6'd0, 64'd255, 1'b1, 1'b0, 1'b0});
    add_row(KIND_BYTE, 8'h00, 1'b0, '0);
    add_row(KIND_BYTE, 8'h01, 1'b0, '0);
    add_row(KIND_CLOSE, 8'h00, 1'b0, '0);
    add_row(KIND_BYTE, 8'h80, 1'b0, '0);
    add_row(KIND_CLOSE, 8'h00, 1'b0, '0);
    add_row(KIND_CLOSE, 8'h00, 1'b0, '0);
    add_row(KIND_SPARE, 8'h55, 1'b0, '0);
    // seven bytes of 255 wrap into a negative key
    repeat (7) add_row(KIND_BYTE, 8'hFF, 1'b0, '0);
    add_row(KIND_CLOSE, 8'h00, 1'b0, '0);
    // trailing bytes never closed
    add_row(KIND_BYTE, 8'h7F, 1'b0, '0);
    add_row(KIND_END, 8'h00, 1'b0, '0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_rows[i]) begin
      row_typed = stim_rows[i].typed;
      row_want = stim_rows[i].want;
      push_item(stim_rows[i].kind, stim_rows[i].value);
    end
    row_typed = 1'b0;
    wait_for_drain();

    list_no = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      // first list fills the store and then overflows it
      if (list_no == 0) strings = CAPACITY + 2;
      else strings = $urandom_range(0, 8);
      broken = ($urandom_range(0, 9) == 0);
      repeat (strings) begin
        // the long list keeps to very short strings so the item count stays modest
        if (strings > 8) nbytes = ($urandom_range(0, 3) == 0) ? 1 : 0;
        else nbytes = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : $urandom_range(0, 2);
        repeat (nbytes) begin
          push_item(KIND_BYTE, pick_byte());
          random_items++;
        end
        if ($urandom_range(0, 11) == 0) push_item(KIND_SPARE, 8'($urandom_range(0, 255)));
        push_item(KIND_CLOSE, 8'($urandom_range(0, 255)));
        random_items++;
      end
      if (broken) begin
        repeat ($urandom_range(1, 3)) begin
          push_item(KIND_BYTE, pick_byte());
          random_items++;
        end
      end
      push_item(KIND_END, 8'($urandom_range(0, 255)));
      random_items++;
      if ($urandom_range(0, 3) == 0) wait_for_drain();
      list_no++;
    end

    in_tvalid = 1'b0;
    while (awaited_entries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
